### hdl/q16_fixed_point_alu_assert.svh
// Assertion macros for the checker file of the fixed-point unit.
`ifndef Q16_FIXED_POINT_ALU_ASSERT_SVH
`define Q16_FIXED_POINT_ALU_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define Q16_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("q16 alu check failed");

// The consequent must hold in the cycle after the antecedent.
`define Q16_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("q16 alu check failed");

`endif

### hdl/q16_alu_pkg.sv
package q16_alu_pkg;

	// Default number of fraction bits.
	localparam int FRAC_BITS_DEF = 16;

	// IEEE single layout.
	localparam int EXP_BIAS = 127;
	localparam int MANT_W   = 23;

	typedef enum logic [1:0] {
		OP_MUL = 2'd0,
		OP_DIV = 2'd1,
		OP_F2F = 2'd2,
		OP_ABS = 2'd3
	} op_e_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [31:0] operand_a;
		logic signed [31:0] operand_b;
	} req_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic               overflow;
		logic               divide_by_zero;
	} rsp_t;

	// Control that travels alongside the datapath through every stage.
	typedef struct packed {
		op_e_t       op;
		logic        neg;
		logic [31:0] res;
		logic        ovf;
		logic        dz;
	} ctrl_t;

	typedef struct packed {
		logic [31:0] res;
		logic        ovf;
	} fin_t;

	// Apply a sign to a magnitude, keep the low 32 bits and flag range overflow.
	function automatic fin_t finish(input logic [63:0] mag, input logic neg);
		fin_t f;
		if (neg) begin
			f.ovf = mag > 64'h0000_0000_8000_0000;
			f.res = 32'd0 - mag[31:0];
		end else begin
			f.ovf = mag > 64'h0000_0000_7fff_ffff;
			f.res = mag[31:0];
		end
		return f;
	endfunction

endpackage

### hdl/q16_alu_prep.sv
module q16_alu_prep #(
	parameter int FRAC_BITS = q16_alu_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  q16_alu_pkg::req_t   req,
	output logic                v_s1,
	output q16_alu_pkg::ctrl_t  ctrl_s1,
	output logic [31:0]         ma_s1,
	output logic [31:0]         mb_s1
);
	import q16_alu_pkg::*;

	localparam int SH_BIAS = EXP_BIAS + MANT_W - FRAC_BITS;

	logic [31:0]        a;
	logic [31:0]        b;
	logic [31:0]        ma;
	logic [31:0]        mb;
	logic               na;
	logic               nb;
	logic [7:0]         expo;
	logic [23:0]        frac;
	logic signed [9:0]  sh;
	logic signed [9:0]  nsh;
	logic [63:0]        fmag;
	fin_t               fin;
	ctrl_t              ctrl;

	// Operand magnitudes and signs.
	always_comb begin
		a  = req.operand_a;
		b  = req.operand_b;
		na = a[31];
		nb = b[31];
		ma = na ? 32'd0 - a : a;
		mb = nb ? 32'd0 - b : b;
	end

	// Float to fixed conversion and the other single-stage operations.
	always_comb begin
		expo = a[30:23];
		frac = {1'b1, a[22:0]};
		sh   = $signed({2'b00, expo}) - 10'(SH_BIAS);
		nsh  = 10'sd0 - sh;
		fmag = 64'd0;
		if (sh >= 10'sd0) begin
			fmag = 64'(frac) << sh[4:0];
		end else if (sh > -10'sd32) begin
			fmag = 64'(frac) >> nsh[4:0];
		end
		ctrl.op  = op_e_t'(req.req_type);
		ctrl.neg = na ^ nb;
		ctrl.res = 32'd0;
		ctrl.ovf = 1'b0;
		ctrl.dz  = 1'b0;
		fin      = finish(fmag, na);
		case (ctrl.op)
			OP_DIV: begin
				ctrl.dz = (b == 32'd0);
			end
			OP_F2F: begin
				if (expo == 8'd0) begin
					ctrl.res = 32'd0;
				end else if (sh >= 10'sd32) begin
					ctrl.ovf = 1'b1;
				end else begin
					ctrl.res = fin.res;
					ctrl.ovf = fin.ovf;
				end
			end
			OP_ABS: begin
				ctrl.res = ma;
				ctrl.ovf = ma[31];
			end
			default: begin
				ctrl.res = 32'd0;
			end
		endcase
	end

	// Stage one registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctrl_s1 <= ctrl;
			ma_s1   <= ma;
			mb_s1   <= mb;
		end
	end

endmodule

### hdl/q16_alu_mul.sv
module q16_alu_mul #(
	parameter int FRAC_BITS = q16_alu_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                en,
	input  logic [31:0]         ma_s1,
	input  logic [31:0]         mb_s1,
	input  q16_alu_pkg::ctrl_t  ctrl_in,
	output q16_alu_pkg::ctrl_t  ctrl_out
);
	import q16_alu_pkg::*;

	logic [63:0] prod_s2;
	fin_t        fin;

	// Full magnitude product, registered before scaling.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= 64'(ma_s1) * 64'(mb_s1);
		end
	end

	// Scale, sign and merge the product into the item's control.
	always_comb begin
		fin      = finish(prod_s2 >> FRAC_BITS, ctrl_in.neg);
		ctrl_out = ctrl_in;
		if (ctrl_in.op == OP_MUL) begin
			ctrl_out.res = fin.res;
			ctrl_out.ovf = fin.ovf;
		end
	end

endmodule

### hdl/q16_alu_div_step.sv
module q16_alu_div_step #(
	parameter int QW = 48
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                v_in,
	input  q16_alu_pkg::ctrl_t  ctrl_in,
	input  logic [31:0]         rem_in,
	input  logic [QW-1:0]       dq_in,
	input  logic [31:0]         mb_in,
	output logic                v_out,
	output q16_alu_pkg::ctrl_t  ctrl_out,
	output logic [31:0]         rem_out,
	output logic [QW-1:0]       dq_out,
	output logic [31:0]         mb_out
);
	import q16_alu_pkg::*;

	logic [32:0] r2;
	logic [32:0] diff;
	logic        ge;

	// One restoring step: bring in the next dividend bit, subtract if it fits.
	always_comb begin
		r2   = {rem_in, dq_in[QW-1]};
		diff = r2 - {1'b0, mb_in};
		ge   = r2 >= {1'b0, mb_in};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (en) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctrl_out <= ctrl_in;
			mb_out   <= mb_in;
			rem_out  <= ge ? diff[31:0] : r2[31:0];
			dq_out   <= {dq_in[QW-2:0], ge};
		end
	end

endmodule

### hdl/q16_fixed_point_alu.sv
// Throughput: one item per cycle while no result is held by a stall; the divider
// retires one quotient bit per stage, so its 32 + FRAC_BITS stages set the depth.
// A stall on the result holds the whole pipeline in place.
// Reset clears only the valid bits of every stage; data registers are not reset.
module q16_fixed_point_alu #(
	parameter int FRAC_BITS = q16_alu_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  q16_alu_pkg::req_t  req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output q16_alu_pkg::rsp_t  rsp
);
	import q16_alu_pkg::*;

	localparam int QW = 32 + FRAC_BITS;

	logic        en;
	logic        v_p    [0:QW];
	ctrl_t       ctrl_p [0:QW];
	logic [31:0] rem_p  [0:QW];
	logic [QW-1:0] dq_p [0:QW];
	logic [31:0] mb_p   [0:QW];
	logic [31:0] ma_s1;
	ctrl_t       ctrl_mul;
	logic        rsp_valid_q;
	rsp_t        rsp_q;
	fin_t        fin;

	// The whole pipeline advances unless a finished item is held at the output.
	assign en        = !(rsp_valid_q && rsp_stall);
	assign req_stall = !en;

	q16_alu_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (req_valid),
		.req      (req),
		.v_s1     (v_p[0]),
		.ctrl_s1  (ctrl_p[0]),
		.ma_s1    (ma_s1),
		.mb_s1    (mb_p[0])
	);

	// The divider starts with an empty remainder and the scaled dividend.
	assign rem_p[0] = 32'd0;
	assign dq_p[0]  = {ma_s1, {FRAC_BITS{1'b0}}};

	q16_alu_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk      (clk),
		.en       (en),
		.ma_s1    (ma_s1),
		.mb_s1    (mb_p[0]),
		.ctrl_in  (ctrl_p[1]),
		.ctrl_out (ctrl_mul)
	);

	// Divider chain; the product joins the item after the first step.
	for (genvar k = 1; k <= QW; k++) begin : g_div
		q16_alu_div_step #(.QW(QW)) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.v_in     (v_p[k-1]),
			.ctrl_in  ((k == 2) ? ctrl_mul : ctrl_p[k-1]),
			.rem_in   (rem_p[k-1]),
			.dq_in    (dq_p[k-1]),
			.mb_in    (mb_p[k-1]),
			.v_out    (v_p[k]),
			.ctrl_out (ctrl_p[k]),
			.rem_out  (rem_p[k]),
			.dq_out   (dq_p[k]),
			.mb_out   (mb_p[k])
		);
	end

	// Final sign and range check of the quotient.
	assign fin = finish({{(64 - QW){1'b0}}, dq_p[QW]}, ctrl_p[QW].neg);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			rsp_valid_q <= v_p[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_q.divide_by_zero <= ctrl_p[QW].dz;
			if (ctrl_p[QW].op == OP_DIV && !ctrl_p[QW].dz) begin
				rsp_q.result_value <= fin.res;
				rsp_q.overflow     <= fin.ovf;
			end else begin
				rsp_q.result_value <= ctrl_p[QW].res;
				rsp_q.overflow     <= ctrl_p[QW].ovf;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### hdl/q16_alu_chk.sv
`include "q16_fixed_point_alu_assert.svh"

module q16_alu_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_stall,
	input q16_alu_pkg::req_t  req,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input q16_alu_pkg::rsp_t  rsp
);
	import q16_alu_pkg::*;

	// A held result stays valid and unchanged.
	`Q16_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

	// Input back-pressure comes only from a result held at the output.
	`Q16_ASSERT_SAME(a_stall_src, req_stall, rsp_valid && rsp_stall)

	// A divide by zero reports a clean zero.
	`Q16_ASSERT_SAME(a_dz_zero, rsp_valid && rsp.divide_by_zero,
		rsp.result_value == 32'sd0 && !rsp.overflow)

	// Overflow and divide by zero never come together.
	`Q16_ASSERT_SAME(a_flags_excl, rsp_valid && rsp.overflow, !rsp.divide_by_zero)

endmodule

bind q16_fixed_point_alu q16_alu_chk u_chk (.*);
